### rtl/slab_pkg.sv
// slab_pkg: shared constants, types and elaboration-time table builders
// for the sRGB to CIELAB pipeline. No dependencies.
package slab_pkg;

  localparam int unsigned LIN_W = 17;   // Q0.16 linear value, 0..65536
  localparam int unsigned T_W   = 17;   // normalized X/Y/Z, up to about 65546
  localparam int unsigned NUM_W = 34;   // normalization numerator
  localparam int unsigned T_MAX = 65546;
  localparam int unsigned PIVOT_KNEE = 580;  // t above this takes the cube root

  typedef logic [LIN_W-1:0] lin_t;
  typedef logic [T_W-1:0]   tval_t;

  // matrix rows, X and Z rows prescaled by 20 to fold in the white-point divide
  localparam int unsigned MAT [3][3] = '{
    '{82480, 71520, 36100},
    '{2126, 7152, 722},
    '{3860, 23840, 190100}
  };
  localparam int unsigned NRM_ADD [3] = '{95047, 5000, 108883};
  localparam int unsigned NRM_DIV [3] = '{190094, 10000, 217766};
  localparam int unsigned NRM_SH  [3] = '{34, 30, 34};
  localparam longint unsigned NRM_REC [3] = '{
    (64'd1 << 34) / 190094,
    (64'd1 << 30) / 10000,
    (64'd1 << 34) / 217766
  };

  // sRGB decode of one 8-bit code into Q0.16
  function automatic lin_t lin_value(input logic [7:0] code);
    logic [63:0] c, t, u, r, cand, p2, p4, p5;
    c = 64'(code);
    r = '0;
    if (c * 64'd100000 <= 64'd1031475) begin
      return lin_t'((c * 64'd13107200 + 64'd329460) / 64'd658920);
    end
    if (c == 64'd255) begin
      return lin_t'(65536);
    end
    t = ((64'd1000 * c + 64'd14025) << 32) / 64'd269025;
    u = (t * t) >> 32;
    for (int b = 15; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      p2 = cand * cand;
      p4 = (p2 * p2) >> 32;
      p5 = (p4 * cand) >> 16;
      if (p5 <= u) begin
        r = cand;
      end
    end
    return lin_t'((u * r + 64'h8000_0000) >> 32);
  endfunction

  function automatic tval_t cbrt_floor(input logic [63:0] v);
    logic [63:0] r, cand;
    r = '0;
    for (int b = 17; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (cand * cand * cand <= v) begin
        r = cand;
      end
    end
    return tval_t'(r);
  endfunction

endpackage

### rtl/slab_if.sv
// slab_pix_if / slab_lab_if: valid/ready channels for the pixel input and
// the Lab result. Depends on nothing.
interface slab_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface slab_lab_if;
  logic               valid;
  logic               ready;
  logic        [14:0] l_star;
  logic signed [15:0] a_star;
  logic signed [15:0] b_star;
  modport source (output valid, l_star, a_star, b_star, input ready);
  modport sink (input valid, l_star, a_star, b_star, output ready);
endinterface

### rtl/slab_xyz.sv
// slab_xyz: four-stage front end: sRGB decode table, matrix to XYZ and
// white-point normalization by reciprocal multiply. Depends on slab_pkg.
module slab_xyz (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [7:0]           red_i,
  input  logic [7:0]           green_i,
  input  logic [7:0]           blue_i,
  output slab_pkg::tval_t      t_o [3]
);

  typedef slab_pkg::lin_t lin_tab_t [256];

  function automatic lin_tab_t build_lin();
    lin_tab_t tab;
    for (int c = 0; c < 256; c++) begin
      tab[c] = slab_pkg::lin_value(8'(c));
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin();

  slab_pkg::lin_t lin_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lin_q[0] <= LIN_TAB[red_i];
      lin_q[1] <= LIN_TAB[green_i];
      lin_q[2] <= LIN_TAB[blue_i];
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    localparam int unsigned SH = slab_pkg::NRM_SH[ch];
    localparam logic [17:0] DIV = 18'(slab_pkg::NRM_DIV[ch]);
    localparam logic [16:0] REC = 17'(slab_pkg::NRM_REC[ch]);

    logic [slab_pkg::NUM_W-1:0]        num_d, num_q, num2_q, rem;
    logic [slab_pkg::NUM_W+16:0]       prod;
    slab_pkg::tval_t                   q0_q, q_q;

    assign num_d = slab_pkg::NUM_W'(18'(slab_pkg::MAT[ch][0]) * lin_q[0])
                 + slab_pkg::NUM_W'(18'(slab_pkg::MAT[ch][1]) * lin_q[1])
                 + slab_pkg::NUM_W'(18'(slab_pkg::MAT[ch][2]) * lin_q[2])
                 + slab_pkg::NUM_W'(slab_pkg::NRM_ADD[ch]);
    assign prod = (slab_pkg::NUM_W+17)'(num_q) * (slab_pkg::NUM_W+17)'(REC);
    // estimate is exact or one low; one compare fixes it
    assign rem = num2_q - slab_pkg::NUM_W'(35'(q0_q) * 35'(DIV));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q  <= num_d;
        num2_q <= num_q;
        q0_q   <= prod[SH +: slab_pkg::T_W];
        q_q    <= q0_q + slab_pkg::T_W'(rem >= slab_pkg::NUM_W'(DIV));
      end
    end

    assign t_o[ch] = q_q;
  end

endmodule

### rtl/slab_pivot.sv
// slab_pivot: three-stage Lab pivot f(t): knot ROM with linear
// interpolation above the knee, scaled line below. Depends on slab_pkg.
module slab_pivot #(
  parameter int ROOT_TABLE_BITS = 10
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  slab_pkg::tval_t t_i,
  output slab_pkg::tval_t f_o
);

  localparam int SHIFT = 16 - ROOT_TABLE_BITS;
  localparam int KNOTS = (slab_pkg::T_MAX >> SHIFT) + 2;
  localparam int IDX_W = slab_pkg::T_W - SHIFT;
  localparam int LN_W  = 25;
  localparam logic [14:0] LIN_REC = 15'((64'd1 << LN_W) / 1160);
  localparam logic [10:0] LIN_DIV = 11'd1160;

  typedef logic [2*slab_pkg::T_W-1:0] rom_t [KNOTS];

  function automatic rom_t build_rom();
    rom_t            tab;
    slab_pkg::tval_t e0, e1;
    for (int k = 0; k < KNOTS; k++) begin
      e0 = slab_pkg::cbrt_floor((64'(k) << SHIFT) << 32);
      e1 = slab_pkg::cbrt_floor((64'(k + 1) << SHIFT) << 32);
      tab[k] = {e1 - e0, e0};
    end
    return tab;
  endfunction

  localparam rom_t KNOT_ROM = build_rom();

  logic [2*slab_pkg::T_W-1:0]      rom_q;
  logic [SHIFT-1:0]                fr_q;
  logic                            above_q, above2_q;
  logic [LN_W-1:0]                 ln_q, ln2_q;
  logic [slab_pkg::T_W+SHIFT-1:0]  interp_d, interp_q;
  slab_pkg::tval_t                 e0_q, lq0_q, f_q, f_d;
  logic [LN_W+14:0]                lprod;
  logic [LN_W-1:0]                 lrem;

  assign interp_d = (slab_pkg::T_W+SHIFT)'(rom_q[2*slab_pkg::T_W-1:slab_pkg::T_W] * fr_q)
                  + (slab_pkg::T_W+SHIFT)'(1 << (SHIFT - 1));
  assign lprod = (LN_W+15)'(ln_q) * (LN_W+15)'(LIN_REC);
  assign lrem  = ln2_q - LN_W'(lq0_q * LIN_DIV);

  always_comb begin
    if (above2_q) begin
      f_d = e0_q + slab_pkg::T_W'(interp_q >> SHIFT);
    end else begin
      f_d = lq0_q + slab_pkg::T_W'(lrem >= LN_W'(LIN_DIV));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rom_q    <= KNOT_ROM[t_i[slab_pkg::T_W-1 -: IDX_W]];
      fr_q     <= t_i[SHIFT-1:0];
      above_q  <= t_i > slab_pkg::T_W'(slab_pkg::PIVOT_KNEE);
      ln_q     <= LN_W'(14'd9033 * t_i[9:0]) + LN_W'(10486340);
      above2_q <= above_q;
      e0_q     <= rom_q[slab_pkg::T_W-1:0];
      interp_q <= interp_d;
      ln2_q    <= ln_q;
      lq0_q    <= slab_pkg::T_W'(lprod >> LN_W);
      f_q      <= f_d;
    end
  end

  assign f_o = f_q;

endmodule

### rtl/slab_out.sv
// slab_out: two-stage back end: L, a, b from the pivots, rounding to
// output units and saturation. Depends on slab_pkg.
module slab_out #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  slab_pkg::tval_t    fx_i,
  input  slab_pkg::tval_t    fy_i,
  input  slab_pkg::tval_t    fz_i,
  output logic        [14:0] l_o,
  output logic signed [15:0] a_o,
  output logic signed [15:0] b_o
);

  localparam int SH   = 16 - FRAC_BITS;
  localparam int LMAX = ((100 << FRAC_BITS) > 32767) ? 32767 : (100 << FRAC_BITS);
  localparam logic signed [27:0] L_HI = 28'(LMAX);
  localparam logic signed [27:0] S_HI = 28'sd32767;
  localparam logic signed [27:0] S_LO = -28'sd32768;

  function automatic logic signed [27:0] to_units(input logic signed [27:0] v);
    logic [27:0] mag, q;
    mag = v[27] ? 28'(-v) : 28'(v);
    q   = (mag + 28'(1 << (SH - 1))) >> SH;
    return v[27] ? -$signed(q) : $signed(q);
  endfunction

  logic signed [27:0] l_q, a_q, b_q, lu, au, bu;
  logic signed [27:0] lc, ac, bc;
  logic        [14:0] lo_q;
  logic signed [15:0] ao_q, bo_q;

  always_comb begin
    lu = to_units(l_q);
    au = to_units(a_q);
    bu = to_units(b_q);
    lc = (lu < 28'sd0) ? 28'sd0 : ((lu > L_HI) ? L_HI : lu);
    ac = (au < S_LO) ? S_LO : ((au > S_HI) ? S_HI : au);
    bc = (bu < S_LO) ? S_LO : ((bu > S_HI) ? S_HI : bu);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_q  <= 28'sd116 * $signed({11'd0, fy_i}) - 28'sd1048576;
      a_q  <= 28'sd500 * ($signed({11'd0, fx_i}) - $signed({11'd0, fy_i}));
      b_q  <= 28'sd200 * ($signed({11'd0, fy_i}) - $signed({11'd0, fz_i}));
      lo_q <= lc[14:0];
      ao_q <= ac[15:0];
      bo_q <= bc[15:0];
    end
  end

  assign l_o = lo_q;
  assign a_o = ao_q;
  assign b_o = bo_q;

endmodule

### rtl/srgb_to_cielab.sv
// srgb_to_cielab: top level; valid pipeline and stall control around the
// XYZ, pivot and output stages. Depends on slab_pkg, slab_if and submodules.
//
// Converts one 8-bit sRGB pixel per clock to CIELAB (D65, 2-degree) with
// L*, a*, b* in units of 2^-FRAC_BITS. The pipeline runs decode, matrix and
// normalization, then the pivot, then scaling and saturation.
// Throughput is one pixel per cycle; the whole pipeline holds while the
// output is valid and not taken. The cube-root knot table has
// 2^ROOT_TABLE_BITS plus a few entries and is read once per pixel channel.
module srgb_to_cielab #(
  parameter int FRAC_BITS       = 8,
  parameter int ROOT_TABLE_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slab_pix_if.sink    pix_i,
  slab_lab_if.source  lab_o
);

  localparam int DEPTH = 9;

  logic [DEPTH-1:0] vld_q, vld_d;
  logic             en;
  slab_pkg::tval_t  t [3];
  slab_pkg::tval_t  f [3];

  assign en = !vld_q[DEPTH-1] || lab_o.ready;
  assign pix_i.ready = en;
  assign vld_d = {vld_q[DEPTH-2:0], pix_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  slab_xyz u_xyz (
    .clk_i   (clk_i),
    .en_i    (en),
    .red_i   (pix_i.red),
    .green_i (pix_i.green),
    .blue_i  (pix_i.blue),
    .t_o     (t)
  );

  for (genvar ch = 0; ch < 3; ch++) begin : g_pivot
    slab_pivot #(.ROOT_TABLE_BITS(ROOT_TABLE_BITS)) u_pivot (
      .clk_i (clk_i),
      .en_i  (en),
      .t_i   (t[ch]),
      .f_o   (f[ch])
    );
  end

  slab_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk_i (clk_i),
    .en_i  (en),
    .fx_i  (f[0]),
    .fy_i  (f[1]),
    .fz_i  (f[2]),
    .l_o   (lab_o.l_star),
    .a_o   (lab_o.a_star),
    .b_o   (lab_o.b_star)
  );

  assign lab_o.valid = vld_q[DEPTH-1];

endmodule
